@@ sv/ppb_pkg.sv @@
// ----------------------------------------------------------------------------
// ppb_pkg
// shared types and constants for the particle projection and bounce unit
// ----------------------------------------------------------------------------
package ppb_pkg;

   localparam int LINE_WIDTH = 320;
   localparam int DIV_NW     = 26;
   localparam int DIV_DW     = 16;
   localparam int CSR_AW     = 3;
   localparam int REQ_W      = 64;
   localparam int RSP_W      = 88;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ROT_COS   = 3'd0,
      CSR_ROT_SIN   = 3'd1,
      CSR_GRAVITY   = 3'd2,
      CSR_DAMP      = 3'd3,
      CSR_FLOOR     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        x_neg;
      logic        b_neg;
      logic        bp_neg;
      logic [15:0] new_y;
      logic [15:0] new_vel;
      logic [15:0] old_y;
      logic [15:0] old_vel;
      logic [6:0]  shade;
      logic        last;
   } side_type;

endpackage

@@ sv/ppb_div.sv @@
// ----------------------------------------------------------------------------
// ppb_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ppb_div #(
   parameter int NW = 26,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   output logic [NW-1:0] quo_out
);
   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] nq_ff  [NW];
   logic [DW-1:0] den_ff [NW];
   logic [DW-1:0] rem_in [NW];
   logic [NW-1:0] nq_in  [NW];

   always_comb begin
      for (int s = 0; s < NW; s++) begin
         logic [DW-1:0] rp;
         logic [NW-1:0] np;
         logic [DW-1:0] dp;
         logic [DW:0]   t;
         rp = (s == 0) ? '0 : rem_ff[(s == 0) ? 0 : s-1];
         np = (s == 0) ? num_in : nq_ff[(s == 0) ? 0 : s-1];
         dp = (s == 0) ? den_in : den_ff[(s == 0) ? 0 : s-1];
         t = {rp, np[NW-1]};
         if (t >= {1'b0, dp}) begin
            rem_in[s] = DW'(t - {1'b0, dp});
            nq_in[s]  = {np[NW-2:0], 1'b1};
         end else begin
            rem_in[s] = t[DW-1:0];
            nq_in[s]  = {np[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NW; s++) begin
            rem_ff[s] <= rem_in[s];
            nq_ff[s]  <= nq_in[s];
            den_ff[s] <= (s == 0) ? den_in : den_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign quo_out = nq_ff[NW-1];

endmodule

@@ sv/particle_project_bounce_unit.sv @@
// ----------------------------------------------------------------------------
// particle_project_bounce_unit
// rotates, projects and bounces one particle per beat
// ----------------------------------------------------------------------------
// throughput: one beat per cycle; the 26 stage dividers set the depth
// the whole pipeline advances unless a held response is not taken
// reset clears valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module particle_project_bounce_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [ppb_pkg::CSR_AW-1:0] csr_addr,
   input  logic [15:0]               csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pos_x, pos_y, pos_z, vel_y
   input  logic [ppb_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // next_y, next_vel, column_ok, screen_col, shadow_ok, shadow_addr,
   // ball_ok, ball_addr, shade_index, zero pad
   output logic [ppb_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);
   import ppb_pkg::*;

   localparam int NV = DIV_NW + 4;

   logic en;
   logic signed [15:0] cos_ff, sin_ff, grav_ff, damp_ff, floor_ff;
   logic [NV-1:0] vld_ff;
   logic rsp_tvalid_ff;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff   <= 16'sd0;
         sin_ff   <= 16'sd0;
         grav_ff  <= 16'sd0;
         damp_ff  <= 16'sd16;
         floor_ff <= 16'sd8000;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROT_COS: cos_ff   <= csr_wdata;
            CSR_ROT_SIN: sin_ff   <= csr_wdata;
            CSR_GRAVITY: grav_ff  <= csr_wdata;
            CSR_DAMP:    damp_ff  <= csr_wdata;
            CSR_FLOOR:   floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[NV-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[NV-1];
      end
   end

   // stage 1: products and gravity
   logic signed [15:0] px, py, pz, pv;
   logic signed [31:0] s1_zc_ff, s1_xs_ff, s1_xc_ff, s1_zs_ff;
   logic signed [15:0] s1_y_ff, s1_v_ff, s1_v1_ff;
   logic s1_last_ff;

   assign px = req_tdata[15:0];
   assign py = req_tdata[31:16];
   assign pz = req_tdata[47:32];
   assign pv = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (en) begin
         s1_zc_ff   <= pz * cos_ff;
         s1_xs_ff   <= px * sin_ff;
         s1_xc_ff   <= px * cos_ff;
         s1_zs_ff   <= pz * sin_ff;
         s1_y_ff    <= py;
         s1_v_ff    <= pv;
         s1_v1_ff   <= pv + grav_ff;
         s1_last_ff <= req_tlast;
      end
   end

   // stage 2: depth, column numerator, bounce product
   logic signed [32:0] rz, rx;
   logic signed [17:0] bp_c;
   logic signed [16:0] yn0_c;
   logic signed [17:0] s2_bp_ff;
   logic signed [26:0] s2_xnum_ff;
   logic signed [16:0] s2_yn0_ff;
   logic signed [33:0] s2_prod_ff;
   logic s2_bounce_ff, s2_last_ff;
   logic signed [15:0] s2_y_ff, s2_v_ff, s2_v1_ff;

   assign rz    = 33'(s1_zc_ff) - 33'(s1_xs_ff);
   assign rx    = 33'(s1_xc_ff) + 33'(s1_zs_ff);
   assign bp_c  = 18'(rz >>> 16) + 18'sd9000;
   assign yn0_c = 17'(s1_y_ff) + 17'(s1_v1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_bp_ff     <= (bp_c == 18'sd0) ? 18'sd1 : bp_c;
         s2_xnum_ff   <= 27'(rx >>> 8) + 27'(rx >>> 11);
         s2_yn0_ff    <= yn0_c;
         s2_bounce_ff <= yn0_c >= 17'(floor_ff);
         s2_prod_ff   <= (-(17'(s1_v1_ff))) * damp_ff;
         s2_y_ff      <= s1_y_ff;
         s2_v_ff      <= s1_v_ff;
         s2_v1_ff     <= s1_v1_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // stage 3: velocity, height, magnitudes and shade
   logic signed [29:0] vb;
   logic signed [15:0] ny_c, nv_c;
   logic signed [21:0] yb_c;
   logic [17:0] bpm;
   logic [11:0] sh_t;
   logic [6:0]  shade_c;
   logic [DIV_NW-1:0] xn_ff, bn_ff, sn_ff;
   logic [DIV_DW-1:0] den_ff;
   side_type side3_ff;

   always_comb begin
      vb = 30'(s2_prod_ff >>> 4);
      if (s2_bounce_ff) begin
         nv_c = vb[15:0];
         ny_c = s2_yn0_ff[15:0] + vb[15:0];
      end else begin
         nv_c = s2_v1_ff;
         ny_c = s2_yn0_ff[15:0];
      end
      yb_c = 22'(ny_c) <<< 6;
      bpm  = s2_bp_ff[17] ? 18'(-s2_bp_ff) : 18'(s2_bp_ff);
      sh_t = 12'(s2_bp_ff >>> 6) & ~12'd3;
      if (s2_bp_ff[17]) begin
         shade_c = '0;
      end else if (sh_t > 12'd127) begin
         shade_c = 7'd127;
      end else begin
         shade_c = sh_t[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xn_ff  <= s2_xnum_ff[26] ? DIV_NW'(-s2_xnum_ff) : DIV_NW'(s2_xnum_ff);
         bn_ff  <= yb_c[21] ? DIV_NW'(-yb_c) : DIV_NW'(yb_c);
         sn_ff  <= DIV_NW'(524288);
         den_ff <= bpm[DIV_DW-1:0];
         side3_ff.x_neg   <= s2_xnum_ff[26];
         side3_ff.b_neg   <= yb_c[21];
         side3_ff.bp_neg  <= s2_bp_ff[17];
         side3_ff.new_y   <= ny_c;
         side3_ff.new_vel <= nv_c;
         side3_ff.old_y   <= s2_y_ff;
         side3_ff.old_vel <= s2_v_ff;
         side3_ff.shade   <= shade_c;
         side3_ff.last    <= s2_last_ff;
      end
   end

   // divider stages
   logic [DIV_NW-1:0] qx, qs, qb;
   side_type side_ff [DIV_NW];

   ppb_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_x (
      .clock(clock), .en(en), .num_in(xn_ff), .den_in(den_ff), .quo_out(qx));
   ppb_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_s (
      .clock(clock), .en(en), .num_in(sn_ff), .den_in(den_ff), .quo_out(qs));
   ppb_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_b (
      .clock(clock), .en(en), .num_in(bn_ff), .den_in(den_ff), .quo_out(qb));

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side3_ff;
         for (int s = 1; s < DIV_NW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // stage 4: signs, column and row checks
   side_type sd;
   logic signed [27:0] col_c, shr_c, br_c;
   logic s4_col_ok_ff, s4_sh_ok_ff, s4_b_ok_ff;
   logic [8:0] s4_col_ff;
   logic [7:0] s4_shr_ff, s4_br_ff;
   side_type s4_side_ff;

   assign sd    = side_ff[DIV_NW-1];
   assign col_c = ((sd.x_neg ^ sd.bp_neg) ? -28'(qx) : 28'(qx)) + 28'sd160;
   assign shr_c = (sd.bp_neg ? -28'(qs) : 28'(qs)) + 28'sd100;
   assign br_c  = ((sd.b_neg ^ sd.bp_neg) ? -28'(qb) : 28'(qb)) + 28'sd100;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_col_ok_ff <= (col_c >= 28'sd0) && (col_c <= 28'sd319);
         s4_sh_ok_ff  <= (shr_c >= 28'sd0) && (shr_c <= 28'sd199);
         s4_b_ok_ff   <= (br_c >= 28'sd0) && (br_c <= 28'sd199);
         s4_col_ff    <= col_c[8:0];
         s4_shr_ff    <= shr_c[7:0];
         s4_br_ff     <= br_c[7:0];
         s4_side_ff   <= sd;
      end
   end

   // output stage: addresses and masking
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff;
   logic [15:0] sh_addr_c, b_addr_c;

   assign sh_addr_c = 16'(s4_shr_ff * LINE_WIDTH) + 16'(s4_col_ff);
   assign b_addr_c  = 16'(s4_br_ff * LINE_WIDTH) + 16'(s4_col_ff);

   always_comb begin
      rsp_data_in = '0;
      if (s4_col_ok_ff) begin
         rsp_data_in[15:0]  = s4_side_ff.new_y;
         rsp_data_in[31:16] = s4_side_ff.new_vel;
         rsp_data_in[32]    = 1'b1;
         rsp_data_in[41:33] = s4_col_ff;
         rsp_data_in[42]    = s4_sh_ok_ff;
         rsp_data_in[58:43] = s4_sh_ok_ff ? sh_addr_c : 16'd0;
         rsp_data_in[59]    = s4_b_ok_ff;
         rsp_data_in[75:60] = s4_b_ok_ff ? b_addr_c : 16'd0;
         rsp_data_in[82:76] = s4_b_ok_ff ? s4_side_ff.shade : 7'd0;
      end else begin
         rsp_data_in[15:0]  = s4_side_ff.old_y;
         rsp_data_in[31:16] = s4_side_ff.old_vel;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_last_ff <= s4_side_ff.last;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/ppb_checker.sv @@
// ----------------------------------------------------------------------------
// ppb_props
// port level checks for the particle projection and bounce unit
// ----------------------------------------------------------------------------
module ppb_props (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ppb_pkg::RSP_W-1:0]  rsp_tdata
);
   import ppb_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request side stalled with free output");

   a_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[82:33] == '0)
      else $error("off screen beat carries projection fields");

   a_shadow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[42] |-> rsp_tdata[58:43] == 16'd0)
      else $error("shadow address without shadow row");

   a_ball: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[59] |-> rsp_tdata[82:60] == '0)
      else $error("ball fields without ball row");

endmodule

bind particle_project_bounce_unit ppb_props u_ppb_props (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

@@ test/ppb_checker.sv @@
// ----------------------------------------------------------------------------
// ppb_checker
// watches the request, response and register channels of the particle
// projection and bounce unit, predicts each response beat and compares it
// field by field with the beat the unit delivers
// ----------------------------------------------------------------------------
module ppb_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [ppb_pkg::CSR_AW-1:0] csr_addr,
   input  logic [15:0]               csr_wdata,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [ppb_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tlast,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [ppb_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      rsp_tlast,
   output int                        fail_count,
   output int                        pending,
   output int                        seen_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ppb_pkg::*;

   typedef struct packed {
      logic        last;
      logic [6:0]  shade;
      logic [15:0] ball_addr;
      logic        ball_ok;
      logic [15:0] shadow_addr;
      logic        shadow_ok;
      logic [8:0]  col;
      logic        col_ok;
      logic [15:0] vel;
      logic [15:0] y;
   } particle_out_type;

   logic signed [15:0] cos_q, sin_q, grav_q, damp_q, floor_q;
   particle_out_type particle_queue[$];

   function automatic longint fshift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return longint'(t);
   endfunction

   function automatic particle_out_type project_particle(logic [63:0] d, logic lst);
      particle_out_type o;
      longint x, y, z, vel, rz, rx, bp, xnum, col, shrow, yn, brow, v, idx;
      o = '0;
      o.last = lst;
      x = longint'($signed(d[15:0]));
      y = longint'($signed(d[31:16]));
      z = longint'($signed(d[47:32]));
      vel = longint'($signed(d[63:48]));
      rz = z * cos_q - x * sin_q;
      bp = fshift(rz, 16) + 9000;
      if (bp == 0) bp = 1;
      rx = x * cos_q + z * sin_q;
      xnum = fshift(rx, 8) + fshift(rx, 11);
      col = xnum / bp + 160;
      if (col < 0 || col > 319) begin
         o.y = y[15:0];
         o.vel = vel[15:0];
         return o;
      end
      o.col_ok = 1'b1;
      o.col = col[8:0];
      shrow = 64'sd524288 / bp + 100;
      if (shrow >= 0 && shrow <= 199) begin
         o.shadow_ok = 1'b1;
         o.shadow_addr = 16'(shrow * LINE_WIDTH + col);
      end
      vel = wrap16(vel + grav_q);
      yn = y + vel;
      if (yn >= floor_q) begin
         v = fshift(-vel * damp_q, 4);
         vel = wrap16(v);
         yn += v;
      end
      yn = wrap16(yn);
      o.y = yn[15:0];
      o.vel = vel[15:0];
      brow = (yn * 64) / bp + 100;
      if (brow >= 0 && brow <= 199) begin
         o.ball_ok = 1'b1;
         o.ball_addr = 16'(brow * LINE_WIDTH + col);
         if (bp < 0) idx = 0;
         else begin
            idx = (bp >>> 6) & ~64'sd3;
            if (idx > 127) idx = 127;
         end
         o.shade = idx[6:0];
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t beat %0d: %s got %0h want %0h", $time, seen_count,
         what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      seen_count = 0;
   end

   assign pending = particle_queue.size();

   always @(posedge clock) begin
      particle_out_type got, want;
      if (reset) begin
         cos_q <= 16'sd0; sin_q <= 16'sd0; grav_q <= 16'sd0; damp_q <= 16'sd16;
         floor_q <= 16'sd8000;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_ROT_COS: cos_q <= csr_wdata;
               CSR_ROT_SIN: sin_q <= csr_wdata;
               CSR_GRAVITY: grav_q <= csr_wdata;
               CSR_DAMP:    damp_q <= csr_wdata;
               CSR_FLOOR:   floor_q <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            particle_queue.push_back(project_particle(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.y = rsp_tdata[15:0];
            got.vel = rsp_tdata[31:16];
            got.col_ok = rsp_tdata[32];
            got.col = rsp_tdata[41:33];
            got.shadow_ok = rsp_tdata[42];
            got.shadow_addr = rsp_tdata[58:43];
            got.ball_ok = rsp_tdata[59];
            got.ball_addr = rsp_tdata[75:60];
            got.shade = rsp_tdata[82:76];
            got.last = rsp_tlast;
            if (particle_queue.size() == 0) begin
               report_mismatch("unexpected beat", longint'(rsp_tdata[63:0]), 0);
            end else begin
               want = particle_queue.pop_front();
               if (got.y != want.y) report_mismatch("next_y", got.y, want.y);
               if (got.vel != want.vel) report_mismatch("next_vel", got.vel, want.vel);
               if (got.col_ok != want.col_ok)
                  report_mismatch("column_ok", got.col_ok, want.col_ok);
               if (got.col != want.col) report_mismatch("screen_col", got.col, want.col);
               if (got.shadow_ok != want.shadow_ok)
                  report_mismatch("shadow_ok", got.shadow_ok, want.shadow_ok);
               if (got.shadow_addr != want.shadow_addr)
                  report_mismatch("shadow_addr", got.shadow_addr, want.shadow_addr);
               if (got.ball_ok != want.ball_ok)
                  report_mismatch("ball_ok", got.ball_ok, want.ball_ok);
               if (got.ball_addr != want.ball_addr)
                  report_mismatch("ball_addr", got.ball_addr, want.ball_addr);
               if (got.shade != want.shade)
                  report_mismatch("shade_index", got.shade, want.shade);
               if (got.last != want.last) report_mismatch("last", got.last, want.last);
               if (rsp_tdata[87:83] != 0) report_mismatch("pad", rsp_tdata[87:83], 0);
            end
            seen_count++;
         end
      end
   end
endmodule

@@ test/tb_particle_project_bounce_unit.sv @@
// ----------------------------------------------------------------------------
// tb_particle_project_bounce_unit
// drives particles through the projection and bounce unit under several
// rotation, gravity, damping and floor settings with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_particle_project_bounce_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ppb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic req_acc_ff = 1'b0;
   int fail_count, pending, seen_count;
   longint cycle_count = 0;
   int stall_mode = 0;

   localparam longint CYCLE_LIMIT = 400000;

   always #1 clock = ~clock;

   particle_project_bounce_unit uut (.*);

   ppb_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("particle_project_bounce_unit verification failed");
         $finish;
      end
   end

   // request beat taken at this edge
   always @(posedge clock) req_acc_ff <= req_tvalid && req_tready;

   // receiver stall pattern
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(3) != 0);
         2: rsp_tready <= ($urandom_range(3) == 0);
         default: rsp_tready <= cycle_count[3];
      endcase
   end

   always @(negedge clock) if (($urandom_range(199)) == 0) stall_mode <= $urandom_range(3);

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_particle(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                logic [15:0] v, logic lst);
      req_tvalid <= 1'b1;
      req_tdata <= {v, z, y, x};
      req_tlast <= lst;
      @(posedge clock);
      @(negedge clock);
      while (!req_acc_ff) begin
         @(posedge clock);
         @(negedge clock);
      end
   endtask

   task automatic send_burst(int count, bit narrow);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clock);
            burst = $urandom_range(1, 24);
         end
         burst--;
         if (narrow)
            send_particle(16'($signed($urandom_range(4000)) - 2000), 16'($urandom),
               16'($signed($urandom_range(30000)) - 15000),
               16'($signed($urandom_range(600)) - 300), 1'($urandom_range(1)));
         else
            send_particle(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               1'($urandom_range(1)));
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_all(logic [15:0] c, logic [15:0] s, logic [15:0] g,
                          logic [15:0] d, logic [15:0] f);
      write_csr(CSR_ROT_COS, c);
      write_csr(CSR_ROT_SIN, s);
      write_csr(CSR_GRAVITY, g);
      write_csr(CSR_DAMP, d);
      write_csr(CSR_FLOOR, f);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // defaults: zero rotation
      send_particle(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      req_tvalid <= 1'b0;
      drain();
      set_all(16'h7fff, 16'h0000, 16'd30, 16'd12, 16'd8000);
      // directed extremes
      send_particle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_particle(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
      send_particle(16'd0, 16'd7990, 16'd0, 16'd20, 1'b0);
      send_particle(16'd0, 16'd100, 16'd0, 16'd5, 1'b1);
      send_particle(16'd2000, 16'hffff, 16'd0, 16'h8000, 1'b0);
      send_particle(16'hf000, 16'd0, 16'd1000, 16'd0, 1'b1);
      // depth of zero and negative depth
      req_tvalid <= 1'b0;
      drain();
      set_all(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
      send_particle(16'd0, 16'd0, 16'd18000, 16'd0, 1'b0);
      send_particle(16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
      send_particle(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_particle(16'h0100, 16'd50, 16'h8000, 16'd3, 1'b1);
      req_tvalid <= 1'b0;
      drain();
      set_all(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      send_particle(16'd100, 16'h7fff, 16'h0, 16'h7fff, 1'b0);
      send_particle(16'hff00, 16'h8000, 16'h100, 16'h8000, 1'b1);
      req_tvalid <= 1'b0;
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 4)
            set_all(16'($urandom_range(32767)), 16'($signed($urandom_range(8000)) - 4000),
               16'($urandom_range(60)), 16'($urandom_range(20)),
               16'($urandom_range(200, 8000)));
         else
            set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
         send_burst(250, (ph % 4) != 3);
         drain();
      end
      $display("covered %0d particle beats over a dozen register settings", seen_count);
      $display("including rail values, zero and negative depth and off-screen columns");
      if (fail_count == 0)
         $display("particle_project_bounce_unit verification clean");
      else
         $display("particle_project_bounce_unit verification failed");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/ppb_pkg.sv
sv/ppb_div.sv
sv/particle_project_bounce_unit.sv
sv/ppb_checker.sv
test/ppb_checker.sv
test/tb_particle_project_bounce_unit.sv
